### rtl/core/pwf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pwf_pkg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FIN
    } t_state;

    typedef enum logic [4:0] {
        OP_CUT,
        OP_DIV,
        OP_S2,
        OP_S3,
        OP_S4,
        OP_S5,
        OP_S6,
        OP_S9,
        OP_S10,
        OP_S11,
        OP_Q45,
        OP_Q6,
        OP_Q5,
        OP_FE,
        OP_FF,
        OP_FH
    } t_op;

    localparam logic [1:0] MODE_ATT = 2'd0;
    localparam logic [1:0] MODE_CUT = 2'd1;
    localparam logic [1:0] MODE_REP = 2'd2;

    localparam logic [2:0] CFG_MODE   = 3'd0;
    localparam logic [2:0] CFG_EFAC   = 3'd1;
    localparam logic [2:0] CFG_FFAC   = 3'd2;
    localparam logic [2:0] CFG_HFAC   = 3'd3;
    localparam logic [2:0] CFG_SIGMA  = 3'd4;
    localparam logic [2:0] CFG_WALL   = 3'd5;
    localparam logic [2:0] CFG_CUTSQ  = 3'd6;
    localparam logic [2:0] CFG_ESHIFT = 3'd7;

    localparam logic [61:0] PMAX   = 62'h3FFF_FFFF_FFFF_FFFF;
    localparam logic [47:0] S48MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] S48MIN = 48'h8000_0000_0000;

    // ceil(2^k / d): k = 68 for 45, k = 65 for 6 and 5
    localparam logic [63:0] RECIP45 = 64'h5B05_B05B_05B0_5B06;
    localparam logic [63:0] RECIP6  = 64'h5555_5555_5555_5556;
    localparam logic [63:0] RECIP5  = 64'h6666_6666_6666_6667;

endpackage

`default_nettype wire

### rtl/core/pwf_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module pwf_mul (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [63:0]  i_a,
    input  wire logic [63:0]  i_b,
    output logic              o_done,
    output logic [127:0]      o_prod
);

    logic [63:0]  r_a;
    logic [63:0]  r_b;
    logic [127:0] r_acc;
    logic [1:0]   r_cnt;
    logic         r_busy;
    logic         r_done;
    logic [31:0]  w_pa;
    logic [31:0]  w_pb;
    logic [63:0]  w_pp;
    logic [127:0] w_sh;

    always_comb begin
        w_pa = r_cnt[1] ? r_a[63:32] : r_a[31:0];
        w_pb = r_cnt[0] ? r_b[63:32] : r_b[31:0];
        w_pp = w_pa * w_pb;
        case (r_cnt)
            2'd0:    w_sh = {64'd0, w_pp};
            2'd3:    w_sh = {w_pp, 64'd0};
            default: w_sh = {32'd0, w_pp, 32'd0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_done <= r_busy && (r_cnt == 2'd3);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 2'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= r_acc + w_sh;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

`default_nettype wire

### rtl/core/pwf_div.sv
`timescale 1ns / 1ps
`default_nettype none

module pwf_div (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [62:0]  i_num,
    input  wire logic [32:0]  i_den,
    output logic              o_done,
    output logic [62:0]       o_quo
);

    logic [62:0] r_quo;
    logic [33:0] r_rem;
    logic [32:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [33:0] w_shift;
    logic [34:0] w_trial;

    always_comb begin
        w_shift = {r_rem[32:0], r_quo[62]};
        w_trial = {1'b0, w_shift} - {2'b00, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == 6'd62);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd62) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (!w_trial[34]) begin
                r_rem <= w_trial[33:0];
                r_quo <= {r_quo[61:0], 1'b1};
            end else begin
                r_rem <= w_shift;
                r_quo <= {r_quo[61:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

### rtl/core/planar_wall_force_93.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                    Payload
// input     in         i_in_valid / o_in_ready      i_atom_z, i_last_atom
// result    out        o_out_valid / i_out_ready    o_force_z .. o_last
// config    in         i_cfg_we                     i_cfg_index, i_cfg_data
//
// A particle's processing time depends on the mode (repulsive, 9-3 or shifted); a particle
// beyond the cutoff finishes early. The bit-serial divider and the 64x64 multiplier
// built from four 32x32 passes set this time. Reset is synchronous, active low, and
// clears control and sums. The next particle is taken while a finished result still
// waits on the output.

module planar_wall_force_93 #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic signed [31:0]  i_atom_z,
    input  wire logic                i_last_atom,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic signed [47:0]       o_force_z,
    output logic signed [47:0]       o_hessian_term,
    output logic signed [47:0]       o_energy_term,
    output logic signed [47:0]       o_energy_total,
    output logic signed [47:0]       o_hessian_total,
    output logic                     o_in_range,
    output logic                     o_overflow,
    output logic                     o_last,
    input  wire logic                i_cfg_we,
    input  wire logic [2:0]          i_cfg_index,
    input  wire logic [47:0]         i_cfg_data
);

    function automatic logic [48:0] f_sat(input logic [48:0] v);
        logic [48:0] res;
        if (v[48] != v[47]) begin
            res = {1'b1, (v[48] ? pwf_pkg::S48MIN : pwf_pkg::S48MAX)};
        end else begin
            res = {1'b0, v[47:0]};
        end
        return res;
    endfunction

    // configuration
    logic [1:0]  r_mode;
    logic [47:0] r_efac;
    logic [47:0] r_ffac;
    logic [47:0] r_hfac;
    logic [30:0] r_sigma;
    logic [31:0] r_wall;
    logic [47:0] r_cut;
    logic [47:0] r_eshift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= pwf_pkg::MODE_ATT;
            r_efac   <= '0;
            r_ffac   <= '0;
            r_hfac   <= '0;
            r_sigma  <= 31'd65536;
            r_wall   <= '0;
            r_cut    <= '0;
            r_eshift <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pwf_pkg::CFG_MODE:   r_mode   <= i_cfg_data[1:0];
                pwf_pkg::CFG_EFAC:   r_efac   <= i_cfg_data;
                pwf_pkg::CFG_FFAC:   r_ffac   <= i_cfg_data;
                pwf_pkg::CFG_HFAC:   r_hfac   <= i_cfg_data;
                pwf_pkg::CFG_SIGMA:  r_sigma  <= i_cfg_data[30:0];
                pwf_pkg::CFG_WALL:   r_wall   <= i_cfg_data[31:0];
                pwf_pkg::CFG_CUTSQ:  r_cut    <= i_cfg_data;
                pwf_pkg::CFG_ESHIFT: r_eshift <= i_cfg_data;
                default:             r_mode   <= r_mode;
            endcase
        end
    end

    // control state
    pwf_pkg::t_state r_state, n_state;
    pwf_pkg::t_op    r_op, n_op;
    logic            r_kick, n_kick;
    logic            r_out_valid, n_out_valid;
    logic [47:0]     r_esum, n_esum;
    logic [47:0]     r_hsum, n_hsum;

    // per-item datapath
    logic [32:0] r_adz, n_adz;
    logic        r_neg, n_neg;
    logic        r_zero, n_zero;
    logic        r_last, n_last;
    logic [1:0]  r_md, n_md;
    logic        r_ovf, n_ovf;
    logic        r_inr, n_inr;
    logic [61:0] r_s, n_s;
    logic [61:0] r_s2, n_s2;
    logic [61:0] r_s3, n_s3;
    logic [61:0] r_s4, n_s4;
    logic [61:0] r_s5, n_s5;
    logic [61:0] r_s6, n_s6;
    logic [61:0] r_s9, n_s9;
    logic [61:0] r_s10, n_s10;
    logic [61:0] r_s11, n_s11;
    logic [61:0] r_q45, n_q45;
    logic [61:0] r_q6, n_q6;
    logic [61:0] r_q5, n_q5;
    logic [47:0] r_ez, n_ez;
    logic [47:0] r_fc, n_fc;
    logic [47:0] r_hz, n_hz;

    // result register
    logic [47:0] r_o_force, n_o_force;
    logic [47:0] r_o_hess, n_o_hess;
    logic [47:0] r_o_energy, n_o_energy;
    logic [47:0] r_o_etot, n_o_etot;
    logic [47:0] r_o_htot, n_o_htot;
    logic        r_o_inr, n_o_inr;
    logic        r_o_ovf, n_o_ovf;
    logic        r_o_last, n_o_last;

    // shared units
    logic         w_mul_start;
    logic [63:0]  w_mul_a;
    logic [63:0]  w_mul_b;
    logic         w_mul_done;
    logic [127:0] w_prod;
    logic         w_div_start;
    logic         w_div_done;
    logic [62:0]  w_quo;

    pwf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    pwf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   ({r_sigma, 32'd0}),
        .i_den   (r_adz),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // brackets and operand selection
    logic [63:0]  w_be;
    logic [63:0]  w_bf;
    logic [63:0]  w_bh;
    logic [47:0]  w_fsel;
    logic [63:0]  w_bsel;
    logic [47:0]  w_fmag;
    logic [63:0]  w_bmag;
    logic         w_fneg;
    logic         w_pw_ovf;
    logic [61:0]  w_pw;
    logic         w_fsat;
    logic [47:0]  w_fres;
    logic [127:0] w_cut_ext;
    logic [32:0]  w_dz;

    always_comb begin
        if (r_md == pwf_pkg::MODE_REP) begin
            w_be = {2'b00, r_s9};
            w_bf = {2'b00, r_s10};
            w_bh = {2'b00, r_s11};
        end else begin
            w_be = {2'b00, r_q45} - {2'b00, r_q6};
            w_bf = {2'b00, r_q5} - {3'b000, r_s4[61:1]};
            w_bh = {2'b00, r_s11} - {2'b00, r_s5};
        end

        case (r_op)
            pwf_pkg::OP_FF: begin
                w_fsel = r_ffac;
                w_bsel = w_bf;
            end
            pwf_pkg::OP_FH: begin
                w_fsel = r_hfac;
                w_bsel = w_bh;
            end
            default: begin
                w_fsel = r_efac;
                w_bsel = w_be;
            end
        endcase
        w_fmag = w_fsel[47] ? (48'd0 - w_fsel) : w_fsel;
        w_bmag = w_bsel[63] ? (64'd0 - w_bsel) : w_bsel;
        w_fneg = w_fsel[47] ^ w_bsel[63];

        case (r_op)
            pwf_pkg::OP_CUT: begin
                w_mul_a = {31'd0, r_adz};
                w_mul_b = {31'd0, r_adz};
            end
            pwf_pkg::OP_S2:  begin w_mul_a = {2'b00, r_s};   w_mul_b = {2'b00, r_s};  end
            pwf_pkg::OP_S3:  begin w_mul_a = {2'b00, r_s2};  w_mul_b = {2'b00, r_s};  end
            pwf_pkg::OP_S4:  begin w_mul_a = {2'b00, r_s2};  w_mul_b = {2'b00, r_s2}; end
            pwf_pkg::OP_S5:  begin w_mul_a = {2'b00, r_s4};  w_mul_b = {2'b00, r_s};  end
            pwf_pkg::OP_S6:  begin w_mul_a = {2'b00, r_s4};  w_mul_b = {2'b00, r_s2}; end
            pwf_pkg::OP_S9:  begin w_mul_a = {2'b00, r_s6};  w_mul_b = {2'b00, r_s3}; end
            pwf_pkg::OP_S10: begin w_mul_a = {2'b00, r_s6};  w_mul_b = {2'b00, r_s4}; end
            pwf_pkg::OP_S11: begin w_mul_a = {2'b00, r_s10}; w_mul_b = {2'b00, r_s};  end
            pwf_pkg::OP_Q45: begin w_mul_a = {2'b00, r_s9};  w_mul_b = pwf_pkg::RECIP45; end
            pwf_pkg::OP_Q6:  begin w_mul_a = {2'b00, r_s3};  w_mul_b = pwf_pkg::RECIP6;  end
            pwf_pkg::OP_Q5:  begin w_mul_a = {2'b00, r_s10}; w_mul_b = pwf_pkg::RECIP5;  end
            default: begin
                w_mul_a = {16'd0, w_fmag};
                w_mul_b = w_bmag;
            end
        endcase

        w_pw_ovf = |w_prod[127:94];
        w_pw     = w_pw_ovf ? pwf_pkg::PMAX : w_prod[93:32];
        w_fsat   = |w_prod[127:79];
        if (w_fsat) begin
            w_fres = w_fneg ? pwf_pkg::S48MIN : pwf_pkg::S48MAX;
        end else if (w_fneg) begin
            w_fres = 48'd0 - {1'b0, w_prod[78:32]};
        end else begin
            w_fres = {1'b0, w_prod[78:32]};
        end

        w_cut_ext = 128'(r_cut) << COORD_FRAC_BITS;
        w_dz      = {i_atom_z[31], i_atom_z} - {r_wall[31], r_wall};
    end

    // finishing adds
    logic [48:0] w_eadd;
    logic [47:0] w_efin;
    logic [48:0] w_fneg_sat;
    logic [47:0] w_ffin;
    logic [48:0] w_esum_sat;
    logic [48:0] w_hsum_sat;
    logic        w_fin_ovf;
    logic [47:0] w_esum_new;
    logic [47:0] w_hsum_new;

    always_comb begin
        w_eadd = f_sat({r_ez[47], r_ez} + {r_eshift[47], r_eshift});
        w_fin_ovf = 1'b0;
        if (r_md == pwf_pkg::MODE_CUT && r_inr) begin
            w_efin    = w_eadd[47:0];
            w_fin_ovf = w_eadd[48];
        end else begin
            w_efin = r_ez;
        end
        w_fneg_sat = f_sat(49'd0 - {r_fc[47], r_fc});
        if (!r_inr || r_zero) begin
            w_ffin = '0;
        end else if (r_neg) begin
            w_ffin    = w_fneg_sat[47:0];
            w_fin_ovf = w_fin_ovf | w_fneg_sat[48];
        end else begin
            w_ffin = r_fc;
        end
        w_esum_sat = f_sat({r_esum[47], r_esum} + {w_efin[47], w_efin});
        w_hsum_sat = f_sat({r_hsum[47], r_hsum} + {r_hz[47], r_hz});
        if (r_inr) begin
            w_esum_new = w_esum_sat[47:0];
            w_hsum_new = w_hsum_sat[47:0];
            w_fin_ovf  = w_fin_ovf | w_esum_sat[48] | w_hsum_sat[48];
        end else begin
            w_esum_new = r_esum;
            w_hsum_new = r_hsum;
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_kick      = 1'b0;
        n_out_valid = r_out_valid;
        n_esum      = r_esum;
        n_hsum      = r_hsum;
        n_adz       = r_adz;
        n_neg       = r_neg;
        n_zero      = r_zero;
        n_last      = r_last;
        n_md        = r_md;
        n_ovf       = r_ovf;
        n_inr       = r_inr;
        n_s         = r_s;
        n_s2        = r_s2;
        n_s3        = r_s3;
        n_s4        = r_s4;
        n_s5        = r_s5;
        n_s6        = r_s6;
        n_s9        = r_s9;
        n_s10       = r_s10;
        n_s11       = r_s11;
        n_q45       = r_q45;
        n_q6        = r_q6;
        n_q5        = r_q5;
        n_ez        = r_ez;
        n_fc        = r_fc;
        n_hz        = r_hz;
        n_o_force   = r_o_force;
        n_o_hess    = r_o_hess;
        n_o_energy  = r_o_energy;
        n_o_etot    = r_o_etot;
        n_o_htot    = r_o_htot;
        n_o_inr     = r_o_inr;
        n_o_ovf     = r_o_ovf;
        n_o_last    = r_o_last;
        w_mul_start = 1'b0;
        w_div_start = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            pwf_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_adz  = w_dz[32] ? (33'd0 - w_dz) : w_dz;
                    n_neg  = w_dz[32];
                    n_zero = (w_dz == 33'd0);
                    n_last = i_last_atom;
                    n_md   = (r_mode == pwf_pkg::MODE_REP || r_mode == pwf_pkg::MODE_CUT)
                             ? r_mode : pwf_pkg::MODE_ATT;
                    n_ovf  = 1'b0;
                    n_inr  = 1'b1;
                    n_ez   = '0;
                    n_fc   = '0;
                    n_hz   = '0;
                    n_op   = (r_mode == pwf_pkg::MODE_CUT) ? pwf_pkg::OP_CUT : pwf_pkg::OP_DIV;
                    n_kick = 1'b1;
                    n_state = pwf_pkg::S_RUN;
                end
            end
            pwf_pkg::S_RUN: begin
                if (r_kick) begin
                    if (r_op == pwf_pkg::OP_DIV) begin
                        if (r_adz == 33'd0) begin
                            n_s    = pwf_pkg::PMAX;
                            n_ovf  = 1'b1;
                            n_op   = pwf_pkg::OP_S2;
                            n_kick = 1'b1;
                        end else begin
                            w_div_start = 1'b1;
                        end
                    end else begin
                        w_mul_start = 1'b1;
                    end
                end
                if (w_div_done) begin
                    if (w_quo[62]) begin
                        n_s   = pwf_pkg::PMAX;
                        n_ovf = 1'b1;
                    end else begin
                        n_s = w_quo[61:0];
                    end
                    n_op   = pwf_pkg::OP_S2;
                    n_kick = 1'b1;
                end
                if (w_mul_done) begin
                    n_kick = 1'b1;
                    case (r_op)
                        pwf_pkg::OP_CUT: begin
                            if (w_prod > w_cut_ext) begin
                                n_inr   = 1'b0;
                                n_kick  = 1'b0;
                                n_state = pwf_pkg::S_FIN;
                            end else begin
                                n_op = pwf_pkg::OP_DIV;
                            end
                        end
                        pwf_pkg::OP_S2: begin
                            n_s2 = w_pw; n_ovf = r_ovf | w_pw_ovf; n_op = pwf_pkg::OP_S3;
                        end
                        pwf_pkg::OP_S3: begin
                            n_s3 = w_pw; n_ovf = r_ovf | w_pw_ovf; n_op = pwf_pkg::OP_S4;
                        end
                        pwf_pkg::OP_S4: begin
                            n_s4 = w_pw; n_ovf = r_ovf | w_pw_ovf; n_op = pwf_pkg::OP_S5;
                        end
                        pwf_pkg::OP_S5: begin
                            n_s5 = w_pw; n_ovf = r_ovf | w_pw_ovf; n_op = pwf_pkg::OP_S6;
                        end
                        pwf_pkg::OP_S6: begin
                            n_s6 = w_pw; n_ovf = r_ovf | w_pw_ovf; n_op = pwf_pkg::OP_S9;
                        end
                        pwf_pkg::OP_S9: begin
                            n_s9 = w_pw; n_ovf = r_ovf | w_pw_ovf; n_op = pwf_pkg::OP_S10;
                        end
                        pwf_pkg::OP_S10: begin
                            n_s10 = w_pw; n_ovf = r_ovf | w_pw_ovf; n_op = pwf_pkg::OP_S11;
                        end
                        pwf_pkg::OP_S11: begin
                            n_s11 = w_pw;
                            n_ovf = r_ovf | w_pw_ovf;
                            n_op  = (r_md == pwf_pkg::MODE_REP) ? pwf_pkg::OP_FE
                                                                : pwf_pkg::OP_Q45;
                        end
                        pwf_pkg::OP_Q45: begin
                            n_q45 = {2'b00, w_prod[127:68]};
                            n_op  = pwf_pkg::OP_Q6;
                        end
                        pwf_pkg::OP_Q6: begin
                            n_q6 = w_prod[126:65];
                            n_op = pwf_pkg::OP_Q5;
                        end
                        pwf_pkg::OP_Q5: begin
                            n_q5 = w_prod[126:65];
                            n_op = pwf_pkg::OP_FE;
                        end
                        pwf_pkg::OP_FE: begin
                            n_ez = w_fres; n_ovf = r_ovf | w_fsat; n_op = pwf_pkg::OP_FF;
                        end
                        pwf_pkg::OP_FF: begin
                            n_fc = w_fres; n_ovf = r_ovf | w_fsat; n_op = pwf_pkg::OP_FH;
                        end
                        default: begin
                            n_hz    = w_fres;
                            n_ovf   = r_ovf | w_fsat;
                            n_kick  = 1'b0;
                            n_state = pwf_pkg::S_FIN;
                        end
                    endcase
                end
            end
            pwf_pkg::S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_o_force   = w_ffin;
                    n_o_hess    = r_hz;
                    n_o_energy  = w_efin;
                    n_o_inr     = r_inr;
                    n_o_ovf     = r_ovf | w_fin_ovf;
                    n_o_last    = r_last;
                    if (r_last) begin
                        n_o_etot = w_esum_new;
                        n_o_htot = w_hsum_new;
                        n_esum   = '0;
                        n_hsum   = '0;
                    end else begin
                        n_o_etot = '0;
                        n_o_htot = '0;
                        n_esum   = w_esum_new;
                        n_hsum   = w_hsum_new;
                    end
                    n_state = pwf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pwf_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pwf_pkg::S_IDLE;
            r_op        <= pwf_pkg::OP_DIV;
            r_kick      <= 1'b0;
            r_out_valid <= 1'b0;
            r_esum      <= '0;
            r_hsum      <= '0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_kick      <= n_kick;
            r_out_valid <= n_out_valid;
            r_esum      <= n_esum;
            r_hsum      <= n_hsum;
        end
    end

    always_ff @(posedge i_clk) begin
        r_adz      <= n_adz;
        r_neg      <= n_neg;
        r_zero     <= n_zero;
        r_last     <= n_last;
        r_md       <= n_md;
        r_ovf      <= n_ovf;
        r_inr      <= n_inr;
        r_s        <= n_s;
        r_s2       <= n_s2;
        r_s3       <= n_s3;
        r_s4       <= n_s4;
        r_s5       <= n_s5;
        r_s6       <= n_s6;
        r_s9       <= n_s9;
        r_s10      <= n_s10;
        r_s11      <= n_s11;
        r_q45      <= n_q45;
        r_q6       <= n_q6;
        r_q5       <= n_q5;
        r_ez       <= n_ez;
        r_fc       <= n_fc;
        r_hz       <= n_hz;
        r_o_force  <= n_o_force;
        r_o_hess   <= n_o_hess;
        r_o_energy <= n_o_energy;
        r_o_etot   <= n_o_etot;
        r_o_htot   <= n_o_htot;
        r_o_inr    <= n_o_inr;
        r_o_ovf    <= n_o_ovf;
        r_o_last   <= n_o_last;
    end

    assign o_in_ready      = (r_state == pwf_pkg::S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_force_z       = r_o_force;
    assign o_hessian_term  = r_o_hess;
    assign o_energy_term   = r_o_energy;
    assign o_energy_total  = r_o_etot;
    assign o_hessian_total = r_o_htot;
    assign o_in_range      = r_o_inr;
    assign o_overflow      = r_o_ovf;
    assign o_last          = r_o_last;

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while an item is in flight");

    a_kick_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kick |-> (r_state == pwf_pkg::S_RUN))
        else $error("unit start outside the run state");

    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mul_done && w_div_done))
        else $error("multiplier and divider finished together");

    a_skip_zero_terms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pwf_pkg::S_FIN && !r_inr) |-> (r_ez == '0 && r_hz == '0))
        else $error("terms set for a particle beyond the cutoff");

endmodule

`default_nettype wire

### test/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int FRAC = 16;
    localparam logic [63:0] PEAK = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam longint MAX48 = 64'sh7FFF_FFFF_FFFF;
    localparam longint MIN48 = -64'sh8000_0000_0000;
    localparam int CYCLE_LIMIT = 1_500_000;

    typedef struct packed {
        logic signed [31:0] z;
        logic               last;
    } t_atom;

    typedef struct packed {
        logic signed [47:0] force_z;
        logic signed [47:0] hess;
        logic signed [47:0] energy;
        logic signed [47:0] e_total;
        logic signed [47:0] h_total;
        logic               in_range;
        logic               ovf;
        logic               last;
    } t_wall_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic signed [31:0] i_atom_z;
    logic               i_last_atom;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [47:0] o_force_z;
    logic signed [47:0] o_hessian_term;
    logic signed [47:0] o_energy_term;
    logic signed [47:0] o_energy_total;
    logic signed [47:0] o_hessian_total;
    logic               o_in_range;
    logic               o_overflow;
    logic               o_last;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_index;
    logic [47:0]        i_cfg_data;

    planar_wall_force_93 #(.COORD_FRAC_BITS(FRAC)) i_dut (.*);

    // wall model state
    logic [1:0]  w_mode;
    longint      w_efac, w_ffac, w_hfac, w_wall, w_shift;
    logic [63:0] w_sigma, w_cutsq;
    longint      e_acc, h_acc;

    t_atom        atom_q[$];
    t_wall_result wall_q[$];
    int  errors;
    int  cycles;
    bit  calm;

    // ready captured at the rising edge for the driver
    logic o_in_ready_seen;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] pow_mul(input logic [63:0] a, input logic [63:0] b,
                                            inout bit ovf);
        logic [127:0] p;
        p = a * b;
        if (p[127:94] != 0) begin
            ovf = 1'b1;
            return PEAK;
        end
        return p[95:32];
    endfunction

    function automatic longint sat48(input longint v, inout bit ovf);
        if (v > MAX48) begin ovf = 1'b1; return MAX48; end
        if (v < MIN48) begin ovf = 1'b1; return MIN48; end
        return v;
    endfunction

    function automatic longint scale_term(input longint f, input longint b, inout bit ovf);
        bit           neg;
        logic [63:0]  mf, mb;
        logic [127:0] p;
        logic [63:0]  mag;
        neg = (f < 0) != (b < 0);
        mf = (f < 0) ? -f : f;
        mb = (b < 0) ? -b : b;
        p = mf * mb;
        if (p[127:79] != 0) begin
            ovf = 1'b1;
            return neg ? MIN48 : MAX48;
        end
        mag = p[95:32];
        if (!neg) begin
            if (mag > 64'(MAX48)) begin ovf = 1'b1; return MAX48; end
            return longint'(mag);
        end
        if (mag > 64'(MAX48) + 1) begin ovf = 1'b1; return MIN48; end
        return -longint'(mag);
    endfunction

    function automatic t_wall_result wall_response(input t_atom a);
        t_wall_result r;
        longint      dz, be, bf, bh, ez, fz, hz, frc;
        logic [63:0] adz, s, s2, s3, s4, s5, s6, s9, s10, s11;
        logic [127:0] d2, c2;
        bit          ovf, inr;
        logic [1:0]  md;
        ovf = 0; inr = 1; ez = 0; fz = 0; hz = 0;
        md = (w_mode == pwf_pkg::MODE_REP) ? pwf_pkg::MODE_REP :
             (w_mode == pwf_pkg::MODE_CUT ? pwf_pkg::MODE_CUT : pwf_pkg::MODE_ATT);
        dz = longint'(a.z) - w_wall;
        adz = (dz < 0) ? -dz : dz;
        if (md == pwf_pkg::MODE_CUT) begin
            d2 = adz * adz;
            c2 = {80'b0, w_cutsq[47:0]} << FRAC;
            if (d2 > c2) inr = 0;
        end
        if (inr) begin
            if (adz == 0) begin
                s = PEAK; ovf = 1;
            end else begin
                s = (w_sigma << 32) / adz;
                if (s > PEAK) begin s = PEAK; ovf = 1; end
            end
            s2 = pow_mul(s, s, ovf);
            s3 = pow_mul(s2, s, ovf);
            s4 = pow_mul(s2, s2, ovf);
            s5 = pow_mul(s4, s, ovf);
            s6 = pow_mul(s4, s2, ovf);
            s9 = pow_mul(s6, s3, ovf);
            s10 = pow_mul(s6, s4, ovf);
            s11 = pow_mul(s10, s, ovf);
            if (md == pwf_pkg::MODE_REP) begin
                be = s9; bf = s10; bh = s11;
            end else begin
                be = longint'(s9 / 45) - longint'(s3 / 6);
                bf = longint'(s10 / 5) - longint'(s4 >> 1);
                bh = longint'(s11) - longint'(s5);
            end
            ez = scale_term(w_efac, be, ovf);
            frc = scale_term(w_ffac, bf, ovf);
            hz = scale_term(w_hfac, bh, ovf);
            if (md == pwf_pkg::MODE_CUT) ez = sat48(ez + w_shift, ovf);
            if (dz > 0) fz = frc;
            else if (dz < 0) fz = sat48(-frc, ovf);
            e_acc = sat48(e_acc + ez, ovf);
            h_acc = sat48(h_acc + hz, ovf);
        end
        r.e_total = 0;
        r.h_total = 0;
        if (a.last) begin
            r.e_total = e_acc[47:0];
            r.h_total = h_acc[47:0];
            e_acc = 0;
            h_acc = 0;
        end
        r.force_z = fz[47:0];
        r.hess = hz[47:0];
        r.energy = ez[47:0];
        r.in_range = inr;
        r.ovf = ovf;
        r.last = a.last;
        return r;
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready_seen) begin
                void'(atom_q.pop_front());
            end
            if (!(i_in_valid && !o_in_ready_seen)) begin
                if (atom_q.size() > 0 && (calm || $urandom_range(99) >= 9)) begin
                    i_in_valid <= 1'b1;
                    i_atom_z <= atom_q[0].z;
                    i_last_atom <= atom_q[0].last;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_ready <= calm || ($urandom_range(99) >= 9);
        end
    end

    always @(posedge i_clk) begin
        o_in_ready_seen <= o_in_ready;
        cycles <= cycles + 1;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            wall_q.push_back(wall_response({i_atom_z, i_last_atom}));
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            t_wall_result got, want;
            got = {o_force_z, o_hessian_term, o_energy_term, o_energy_total,
                   o_hessian_total, o_in_range, o_overflow, o_last};
            if (wall_q.size() == 0) begin
                errors <= errors + 1;
                if (errors < 10) $display("unexpected transfer: %p", got);
            end else begin
                want = wall_q.pop_front();
                if (got !== want) begin
                    errors <= errors + 1;
                    if (errors < 10) $display("mismatch: expected %p got %p", want, got);
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic cfg_write(input logic [2:0] idx, input logic [47:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            pwf_pkg::CFG_MODE:   w_mode = val[1:0];
            pwf_pkg::CFG_EFAC:   w_efac = longint'($signed(val));
            pwf_pkg::CFG_FFAC:   w_ffac = longint'($signed(val));
            pwf_pkg::CFG_HFAC:   w_hfac = longint'($signed(val));
            pwf_pkg::CFG_SIGMA:  w_sigma = {33'b0, val[30:0]};
            pwf_pkg::CFG_WALL:   w_wall = longint'($signed(val[31:0]));
            pwf_pkg::CFG_CUTSQ:  w_cutsq = {16'b0, val};
            pwf_pkg::CFG_ESHIFT: w_shift = longint'($signed(val));
            default: ;
        endcase
    endtask

    task automatic drain;
        wait (atom_q.size() == 0 && !i_in_valid);
        wait (wall_q.size() == 0);
        repeat (200) @(posedge i_clk);
    endtask

    function automatic logic [47:0] rnd48;
        return 48'({$urandom, $urandom});
    endfunction

    function automatic logic [47:0] small_factor;
        logic [47:0] v;
        v = {16'b0, $urandom} >> $urandom_range(20);
        return $urandom_range(1) ? -v : v;
    endfunction

    task automatic random_setting(input logic [1:0] md);
        cfg_write(pwf_pkg::CFG_MODE, 48'(md));
        cfg_write(pwf_pkg::CFG_EFAC, $urandom_range(9) == 0 ? rnd48() : small_factor());
        cfg_write(pwf_pkg::CFG_FFAC, $urandom_range(9) == 0 ? rnd48() : small_factor());
        cfg_write(pwf_pkg::CFG_HFAC, $urandom_range(9) == 0 ? rnd48() : small_factor());
        cfg_write(pwf_pkg::CFG_SIGMA, $urandom_range(9) == 0 ? 48'({$urandom} >> 1)
                                                    : 48'($urandom_range(32768, 131072)));
        cfg_write(pwf_pkg::CFG_WALL,
                  48'($signed(32'($urandom_range(0, 400000)) - 32'sd200000)));
        cfg_write(pwf_pkg::CFG_CUTSQ,
                  $urandom_range(4) == 0 ? rnd48() : 48'($urandom_range(1 << 20)));
        cfg_write(pwf_pkg::CFG_ESHIFT, $urandom_range(4) == 0 ? rnd48() : small_factor());
    endtask

    function automatic t_atom rand_atom(input int frame_len, input int k);
        t_atom a;
        case ($urandom_range(9))
            0: a.z = $urandom;
            1: a.z = 32'($signed(w_wall[31:0]) + $signed(32'($urandom_range(0, 4)) - 32'sd2));
            default: a.z = 32'($signed(w_wall[31:0]) +
                               $signed(32'($urandom_range(0, 1 << 19)) - 32'sd262144));
        endcase
        a.last = (k == frame_len - 1);
        return a;
    endfunction

    initial begin
        int phase;
        int flen;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_atom_z = '0;
        i_last_atom = 1'b0;
        i_out_ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = pwf_pkg::CFG_MODE;
        i_cfg_data = '0;
        errors = 0;
        cycles = 0;
        calm = 1'b0;
        w_mode = pwf_pkg::MODE_ATT; w_efac = 0; w_ffac = 0; w_hfac = 0; w_shift = 0;
        w_sigma = 65536; w_wall = 0; w_cutsq = 0; e_acc = 0; h_acc = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, zero distance, every mode
        cfg_write(pwf_pkg::CFG_EFAC, 48'h0000_0100_0000);
        cfg_write(pwf_pkg::CFG_FFAC, 48'hFFFF_FF00_0000);
        cfg_write(pwf_pkg::CFG_HFAC, 48'h0000_0001_0000);
        atom_q.push_back('{32'sh7FFF_FFFF, 1'b0});
        atom_q.push_back('{32'sh8000_0000, 1'b0});
        atom_q.push_back('{32'sd0, 1'b0});
        atom_q.push_back('{32'sd65536, 1'b0});
        atom_q.push_back('{-32'sd65536, 1'b1});
        drain();
        cfg_write(pwf_pkg::CFG_MODE, 48'(pwf_pkg::MODE_CUT));
        cfg_write(pwf_pkg::CFG_CUTSQ, 48'd4 << 16);
        cfg_write(pwf_pkg::CFG_ESHIFT, 48'hFFFF_FFF0_0000);
        atom_q.push_back('{32'sd65536, 1'b0});
        atom_q.push_back('{32'sd131072, 1'b0});
        atom_q.push_back('{32'sd131073, 1'b0});
        atom_q.push_back('{32'sd900000, 1'b1});
        atom_q.push_back('{32'sd900000, 1'b1});
        drain();
        cfg_write(pwf_pkg::CFG_MODE, 48'(pwf_pkg::MODE_REP));
        cfg_write(pwf_pkg::CFG_SIGMA, 48'h7FFF_FFFF);
        cfg_write(pwf_pkg::CFG_WALL, 48'hFFFF_8000_0000);
        atom_q.push_back('{32'sh7FFF_FFFF, 1'b0});
        atom_q.push_back('{32'sh8000_0001, 1'b0});
        atom_q.push_back('{32'sh8000_0000, 1'b1});
        drain();
        cfg_write(pwf_pkg::CFG_MODE, 48'd3);
        cfg_write(pwf_pkg::CFG_SIGMA, 48'd0);
        cfg_write(pwf_pkg::CFG_WALL, 48'h0000_7FFF_FFFF);
        cfg_write(pwf_pkg::CFG_CUTSQ, 48'hFFFF_FFFF_FFFF);
        cfg_write(pwf_pkg::CFG_EFAC, 48'h7FFF_FFFF_FFFF);
        cfg_write(pwf_pkg::CFG_FFAC, 48'h8000_0000_0000);
        cfg_write(pwf_pkg::CFG_HFAC, 48'h8000_0000_0000);
        cfg_write(pwf_pkg::CFG_ESHIFT, 48'h7FFF_FFFF_FFFF);
        atom_q.push_back('{32'sd0, 1'b0});
        atom_q.push_back('{32'sh7FFF_FFFF, 1'b1});
        drain();

        // random frames over several settings
        for (phase = 0; phase < 11; phase++) begin
            random_setting(2'(phase % 3));
            calm = (phase == 5);
            for (int n = 0; n < 50; ) begin
                flen = $urandom_range(1, 8);
                for (int k = 0; k < flen; k++) atom_q.push_back(rand_atom(flen, k));
                n += flen;
            end
            drain();
        end
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

### files.f
rtl/core/pwf_pkg.sv
rtl/core/pwf_mul.sv
rtl/core/pwf_div.sv
rtl/core/planar_wall_force_93.sv
test/tb.sv
